### sv/bsls_pkg.sv
// ----------------------------------------------------------------------------
// bsls_pkg: shared types and constants of the bounded sequence list store
// Capacity, field widths, action and status codes, controller states,
// datapath operations and the status bundle returned to the controller.
// ----------------------------------------------------------------------------
package bsls_pkg;

  // storage depth and derived widths
  localparam int CAPACITY = 16;
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  // fixed field widths
  localparam int ACT_W = 3;
  localparam int VAL_W = 32;
  localparam int POS_W = 9;
  localparam int CNT_W = 9;

  // action codes carried by an input beat
  typedef enum logic [ACT_W-1:0] {
    ACT_INS_HEAD = 3'd0,
    ACT_INS_TAIL = 3'd1,
    ACT_DELETE   = 3'd2,
    ACT_REVERSE  = 3'd3,
    ACT_MIDDLE   = 3'd4,
    ACT_DUMP     = 3'd5
  } action_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REV_SHIFT,
    S_DUMP
  } state_t;

  // datapath operation issued by the controller each cycle
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_EXEC,
    OP_FLIP,
    OP_SHIFT,
    OP_REV_DONE,
    OP_DUMP_EMIT
  } dp_op_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic is_rev;
    logic is_dump;
    logic len_zero;
    logic cnt_zero;
    logic dump_last;
    logic out_free;
  } dp_stat_t;

endpackage

### sv/bounded_sequence_list_store.sv
// an insert, delete, middle, empty dump or unused action is captured, then loads its result
// from the execute state; a dump loads its first beat there, then one beat per cycle while the
// output register is free; reverse loads after one mirror step, then one realignment shift
// per unused cell; a busy output register delays each load until it frees
// a new beat is not accepted while one is in progress; the next beat is accepted the cycle
// after the previous final result is loaded; reset (sync, active high) empties list and output valid
// ----------------------------------------------------------------------------
// bounded_sequence_list_store: ordered list of signed 32-bit values
// Insert at head or tail, delete at a position, reverse, middle query and
// dump, with count and status on every result beat.
// ----------------------------------------------------------------------------
module bounded_sequence_list_store (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bsls_pkg::ACT_W-1:0]         action,
  input  logic signed [bsls_pkg::VAL_W-1:0]  item_value,
  input  logic [bsls_pkg::POS_W-1:0]         position,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [bsls_pkg::VAL_W-1:0]  result_value,
  output logic [bsls_pkg::CNT_W-1:0]         element_count,
  output logic [1:0]                         status,
  output logic                               last
);

  bsls_pkg::dp_op_t   op;
  bsls_pkg::dp_stat_t stat;

  // sequencing controller
  bsls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .op       (op)
  );

  // list datapath and result register
  bsls_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .stat          (stat),
    .action        (action),
    .item_value    (item_value),
    .position      (position),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_value  (result_value),
    .element_count (element_count),
    .status        (status),
    .last          (last)
  );

endmodule

### sv/bsls_ctrl.sv
// ----------------------------------------------------------------------------
// bsls_ctrl: sequencing controller
// Captures one input beat, then steps the datapath through the update,
// the multi-cycle reverse realignment or the element-by-element dump.
// ----------------------------------------------------------------------------
module bsls_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bsls_pkg::dp_stat_t stat,
  output bsls_pkg::dp_op_t   op
);

  bsls_pkg::state_t state;
  bsls_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsls_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bsls_pkg::S_IDLE: begin
        if (in_valid) state_next = bsls_pkg::S_EXEC;
      end
      bsls_pkg::S_EXEC: begin
        if (stat.is_rev) begin
          state_next = bsls_pkg::S_REV_SHIFT;
        end else if (stat.is_dump && !stat.len_zero) begin
          if (stat.out_free && stat.dump_last) state_next = bsls_pkg::S_IDLE;
          else state_next = bsls_pkg::S_DUMP;
        end else if (stat.out_free) begin
          state_next = bsls_pkg::S_IDLE;
        end
      end
      bsls_pkg::S_REV_SHIFT: begin
        if (stat.cnt_zero && stat.out_free) state_next = bsls_pkg::S_IDLE;
      end
      bsls_pkg::S_DUMP: begin
        if (stat.out_free && stat.dump_last) state_next = bsls_pkg::S_IDLE;
      end
      default: state_next = bsls_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    op       = bsls_pkg::OP_NONE;
    in_ready = 1'b0;
    case (state)
      bsls_pkg::S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) op = bsls_pkg::OP_CAPTURE;
      end
      bsls_pkg::S_EXEC: begin
        if (stat.is_rev) begin
          op = bsls_pkg::OP_FLIP;
        end else if (stat.is_dump && !stat.len_zero) begin
          if (stat.out_free) op = bsls_pkg::OP_DUMP_EMIT;
        end else if (stat.out_free) begin
          op = bsls_pkg::OP_EXEC;
        end
      end
      bsls_pkg::S_REV_SHIFT: begin
        if (!stat.cnt_zero) op = bsls_pkg::OP_SHIFT;
        else if (stat.out_free) op = bsls_pkg::OP_REV_DONE;
      end
      bsls_pkg::S_DUMP: begin
        if (stat.out_free) op = bsls_pkg::OP_DUMP_EMIT;
      end
      default: op = bsls_pkg::OP_NONE;
    endcase
  end

`ifndef SYNTH
  // a final dump beat always returns the controller to idle
  a_dump_end: assert property (@(posedge clk) disable iff (rst)
    (state == bsls_pkg::S_DUMP && op == bsls_pkg::OP_DUMP_EMIT && stat.dump_last)
    |=> state == bsls_pkg::S_IDLE)
    else $error("dump did not finish after last beat");

  // a reverse always passes through realignment before reporting
  a_rev_path: assert property (@(posedge clk) disable iff (rst)
    op == bsls_pkg::OP_FLIP |=> state == bsls_pkg::S_REV_SHIFT)
    else $error("flip not followed by realignment");

  // a new beat is captured only from idle
  a_capture_idle: assert property (@(posedge clk) disable iff (rst)
    op == bsls_pkg::OP_CAPTURE |-> state == bsls_pkg::S_IDLE && in_valid)
    else $error("capture outside idle");
`endif

endmodule

### sv/bsls_dp.sv
// ----------------------------------------------------------------------------
// bsls_dp: element cells, length, step counter and result register
// Cells shift up, shift down or mirror in parallel; one read port serves
// the middle query and the dump; the result register holds one beat.
// ----------------------------------------------------------------------------
module bsls_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  bsls_pkg::dp_op_t                   op,
  output bsls_pkg::dp_stat_t                 stat,
  input  logic [bsls_pkg::ACT_W-1:0]         action,
  input  logic signed [bsls_pkg::VAL_W-1:0]  item_value,
  input  logic [bsls_pkg::POS_W-1:0]         position,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [bsls_pkg::VAL_W-1:0]  result_value,
  output logic [bsls_pkg::CNT_W-1:0]         element_count,
  output logic [1:0]                         status,
  output logic                               last
);

  localparam int CAP   = bsls_pkg::CAPACITY;
  localparam int LEN_W = bsls_pkg::LEN_W;
  localparam int IDX_W = bsls_pkg::IDX_W;
  localparam int VAL_W = bsls_pkg::VAL_W;
  localparam int POS_W = bsls_pkg::POS_W;

  // captured input beat
  logic [bsls_pkg::ACT_W-1:0] act;
  logic signed [VAL_W-1:0]    val;
  logic [POS_W-1:0]           pos;

  // list state
  logic signed [VAL_W-1:0] cells      [CAP];
  logic signed [VAL_W-1:0] cells_next [CAP];
  logic [LEN_W-1:0]        len;
  logic [LEN_W-1:0]        len_next;
  logic [LEN_W-1:0]        cnt;
  logic [LEN_W-1:0]        cnt_next;

  // result register
  logic                    load;
  logic signed [VAL_W-1:0] res_val;
  bsls_pkg::status_t       res_st;
  logic                    res_last;
  bsls_pkg::status_t       status_q;

  // derived conditions
  logic             full;
  logic             pos_bad;
  logic [POS_W-1:0] pos_m1;
  logic [IDX_W-1:0] rd_idx;
  logic signed [VAL_W-1:0] rd_data;
  logic             dump_last;

  assign full      = (len == LEN_W'(CAP));
  assign pos_bad   = (pos == '0) || (pos > POS_W'(len));
  assign pos_m1    = pos - POS_W'(1);
  assign dump_last = ((cnt + LEN_W'(1)) == len);

  // single read port: dump index or middle element
  assign rd_idx  = (op == bsls_pkg::OP_DUMP_EMIT) ? cnt[IDX_W-1:0] : IDX_W'(len >> 1);
  assign rd_data = cells[rd_idx];

  // status back to the controller
  assign stat.is_rev    = (act == bsls_pkg::ACT_REVERSE);
  assign stat.is_dump   = (act == bsls_pkg::ACT_DUMP);
  assign stat.len_zero  = (len == '0);
  assign stat.cnt_zero  = (cnt == '0);
  assign stat.dump_last = dump_last;
  assign stat.out_free  = !out_valid || out_ready;

  // cell, length, counter and result next values
  always_comb begin
    for (int i = 0; i < CAP; i++) cells_next[i] = cells[i];
    len_next = len;
    cnt_next = cnt;
    load     = 1'b0;
    res_val  = '0;
    res_st   = bsls_pkg::ST_OK;
    res_last = 1'b1;
    case (op)
      bsls_pkg::OP_CAPTURE: begin
        cnt_next = '0;
      end
      bsls_pkg::OP_EXEC: begin
        load = 1'b1;
        case (act)
          bsls_pkg::ACT_INS_HEAD: begin
            if (full) begin
              res_st = bsls_pkg::ST_FULL;
            end else begin
              for (int i = 1; i < CAP; i++) cells_next[i] = cells[i-1];
              cells_next[0] = val;
              len_next = len + LEN_W'(1);
            end
          end
          bsls_pkg::ACT_INS_TAIL: begin
            if (full) begin
              res_st = bsls_pkg::ST_FULL;
            end else begin
              cells_next[len[IDX_W-1:0]] = val;
              len_next = len + LEN_W'(1);
            end
          end
          bsls_pkg::ACT_DELETE: begin
            if (pos_bad) begin
              res_st = bsls_pkg::ST_BADPOS;
            end else begin
              for (int i = 0; i < CAP - 1; i++) begin
                if (POS_W'(i) >= pos_m1) cells_next[i] = cells[i+1];
              end
              len_next = len - LEN_W'(1);
            end
          end
          bsls_pkg::ACT_MIDDLE: begin
            if (len == '0) res_st = bsls_pkg::ST_EMPTY;
            else res_val = rd_data;
          end
          bsls_pkg::ACT_DUMP: begin
            res_st = bsls_pkg::ST_EMPTY;
          end
          default: res_st = bsls_pkg::ST_OK;
        endcase
      end
      bsls_pkg::OP_FLIP: begin
        // mirror the whole array, then realign by the unused depth
        for (int i = 0; i < CAP; i++) cells_next[i] = cells[CAP-1-i];
        cnt_next = LEN_W'(CAP) - len;
      end
      bsls_pkg::OP_SHIFT: begin
        for (int i = 0; i < CAP - 1; i++) cells_next[i] = cells[i+1];
        cnt_next = cnt - LEN_W'(1);
      end
      bsls_pkg::OP_REV_DONE: begin
        load = 1'b1;
      end
      bsls_pkg::OP_DUMP_EMIT: begin
        load     = 1'b1;
        res_val  = rd_data;
        res_last = dump_last;
        cnt_next = cnt + LEN_W'(1);
      end
      default: load = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      len <= len_next;
      cnt <= cnt_next;
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (op == bsls_pkg::OP_CAPTURE) begin
      act <= action;
      val <= item_value;
      pos <= position;
    end
    for (int i = 0; i < CAP; i++) cells[i] <= cells_next[i];
    if (load) begin
      result_value  <= res_val;
      element_count <= bsls_pkg::CNT_W'(len_next);
      status_q      <= res_st;
      last          <= res_last;
    end
  end

  assign status = status_q;

`ifndef SYNTH
  // length stays within capacity
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(CAP))
    else $error("length beyond capacity");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> !out_valid || out_ready)
    else $error("result register overwritten");

  // realignment shifts only while steps remain
  a_shift_cnt: assert property (@(posedge clk) disable iff (rst)
    op == bsls_pkg::OP_SHIFT |-> cnt != '0)
    else $error("shift with zero count");

  // dump beats only read stored elements
  a_dump_range: assert property (@(posedge clk) disable iff (rst)
    op == bsls_pkg::OP_DUMP_EMIT |-> cnt < len)
    else $error("dump index beyond length");
`endif

endmodule
